// ===== rtl/core/mta_pkg.sv =====
// Shared constants, command and status types for the mesh tangent accumulator.
// Used by mta_ctrl, mta_dp and the top level; depends on nothing.
package mta_pkg;

  localparam int unsigned VERTEX_COUNT = 4096;
  localparam int unsigned ADDR_W       = $clog2(VERTEX_COUNT);
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned COUNT_BITS   = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int unsigned POS_W  = 48;
  localparam int unsigned TEX_W  = 32;
  localparam int unsigned Q_W    = 20;
  localparam int unsigned VEC_W  = 3 * Q_W;
  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Products of two 17-bit deltas, and their differences.
  localparam int unsigned DELTA_W = 17;
  localparam int unsigned PROD_W  = 2 * DELTA_W + 1;
  // Mean accumulator: old * count + fresh.
  localparam int unsigned MACC_W  = Q_W + COUNT_BITS + 2;

  // Divider: quotient bits, numerator, remainder and shifted divisor widths.
  localparam int unsigned QUO_W = Q_W + 1;
  localparam int unsigned NUM_W = PROD_W + 17;
  localparam int unsigned REM_W = NUM_W + 1;
  localparam int unsigned DSH_W = PROD_W + QUO_W;
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  localparam int unsigned MUL_STEPS = 14;
  localparam int unsigned DIV_JOBS  = 6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_MUL,
    OP_SOLVE,
    OP_READ,
    OP_MMUL,
    OP_MDIV,
    OP_WRITE
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [3:0]        step;
    logic              vec;
    logic [1:0]        comp;
    logic [1:0]        corner;
    logic [ADDR_W-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/mta_ctrl.sv =====
// Sequencer of the mesh tangent accumulator: clearing pass, products,
// divisions and per-vertex updates. Depends on mta_pkg.
module mta_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output mta_pkg::cmd_t  cmd_o,
  input  mta_pkg::stat_t stat_i
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MUL   = 10'b0000000100,
    S_SOLVE = 10'b0000001000,
    S_SWAIT = 10'b0000010000,
    S_READ  = 10'b0000100000,
    S_MMUL  = 10'b0001000000,
    S_MDIV  = 10'b0010000000,
    S_MWAIT = 10'b0100000000,
    S_WRITE = 10'b1000000000
  } state_e;

  state_e                    state_q, state_d;
  logic [3:0]                step_q, step_d;
  logic [2:0]                job_q, job_d;
  logic [1:0]                corner_q, corner_d;
  logic [mta_pkg::ADDR_W-1:0] clr_q, clr_d;
  logic                      vec;
  logic [1:0]                comp;

  // Jobs 0 to 2 are tangent components, 3 to 5 bitangent components.
  assign vec  = (job_q >= 3'd3);
  assign comp = vec ? 2'(job_q - 3'd3) : job_q[1:0];

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    job_d    = job_q;
    corner_d = corner_q;
    clr_d    = clr_q;
    cmd_o.op       = mta_pkg::OP_NONE;
    cmd_o.step     = step_q;
    cmd_o.vec      = vec;
    cmd_o.comp     = comp;
    cmd_o.corner   = corner_q;
    cmd_o.clr_addr = clr_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = mta_pkg::OP_CLEAR;
        clr_d    = clr_q + 1'b1;
        if (clr_q == mta_pkg::ADDR_W'(mta_pkg::VERTEX_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mta_pkg::OP_CAPTURE;
          step_d   = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = mta_pkg::OP_MUL;
        if (step_q == 4'(mta_pkg::MUL_STEPS - 1)) begin
          job_d   = '0;
          state_d = S_SOLVE;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_SOLVE: begin
        cmd_o.op = mta_pkg::OP_SOLVE;
        state_d  = S_SWAIT;
      end
      S_SWAIT: begin
        if (!stat_i.div_busy) begin
          if (job_q == 3'(mta_pkg::DIV_JOBS - 1)) begin
            job_d    = '0;
            corner_d = '0;
            state_d  = S_READ;
          end else begin
            job_d   = job_q + 3'd1;
            state_d = S_SOLVE;
          end
        end
      end
      S_READ: begin
        cmd_o.op = mta_pkg::OP_READ;
        job_d    = '0;
        state_d  = S_MMUL;
      end
      S_MMUL: begin
        cmd_o.op = mta_pkg::OP_MMUL;
        state_d  = S_MDIV;
      end
      S_MDIV: begin
        cmd_o.op = mta_pkg::OP_MDIV;
        state_d  = S_MWAIT;
      end
      S_MWAIT: begin
        if (!stat_i.div_busy) begin
          if (job_q == 3'(mta_pkg::DIV_JOBS - 1)) begin
            state_d = S_WRITE;
          end else begin
            job_d   = job_q + 3'd1;
            state_d = S_MMUL;
          end
        end
      end
      S_WRITE: begin
        if (stat_i.out_free) begin
          cmd_o.op = mta_pkg::OP_WRITE;
          if (corner_q == 2'd2) begin
            state_d = S_IDLE;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d  = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      step_q   <= '0;
      job_q    <= '0;
      corner_q <= '0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      job_q    <= job_d;
      corner_q <= corner_d;
      clr_q    <= clr_d;
    end
  end

`ifndef SYNTHESIS
  a_write_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == mta_pkg::OP_WRITE |-> stat_i.out_free)
    else $error("result written while output slot occupied");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == mta_pkg::OP_SOLVE || cmd_o.op == mta_pkg::OP_MDIV) |-> !stat_i.div_busy)
    else $error("divider started while busy");

  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL && step_q == 4'd0))
    else $error("accepted item did not start the product sequence");
`endif

endmodule

// ===== rtl/core/mta_dp.sv =====
// Datapath of the mesh tangent accumulator: deltas, shared multiplier,
// bit-serial divider, vertex stores and the output register. Depends on mta_pkg.
module mta_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mta_pkg::cmd_t              cmd_i,
  output mta_pkg::stat_t             stat_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic [mta_pkg::IDX_W-1:0]  first_index_i,
  input  logic [mta_pkg::IDX_W-1:0]  second_index_i,
  input  logic [mta_pkg::IDX_W-1:0]  third_index_i,
  input  logic [mta_pkg::POS_W-1:0]  first_position_i,
  input  logic [mta_pkg::POS_W-1:0]  second_position_i,
  input  logic [mta_pkg::POS_W-1:0]  third_position_i,
  input  logic [mta_pkg::TEX_W-1:0]  first_texcoord_i,
  input  logic [mta_pkg::TEX_W-1:0]  second_texcoord_i,
  input  logic [mta_pkg::TEX_W-1:0]  third_texcoord_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [mta_pkg::IDX_W-1:0]  vertex_index_o,
  output logic [mta_pkg::VEC_W-1:0]  tangent_o,
  output logic [mta_pkg::VEC_W-1:0]  bitangent_o,
  output logic                       degenerate_o,
  output logic                       last_o
);

  localparam int unsigned DW  = mta_pkg::DELTA_W;
  localparam int unsigned PW  = mta_pkg::PROD_W;
  localparam int unsigned QW  = mta_pkg::Q_W;
  localparam int unsigned MW  = mta_pkg::MACC_W;
  localparam int unsigned NW  = mta_pkg::NUM_W;
  localparam int unsigned RW  = mta_pkg::REM_W;
  localparam int unsigned SW  = mta_pkg::DSH_W;
  localparam int unsigned UW  = mta_pkg::QUO_W;
  localparam int unsigned CW  = mta_pkg::CNT_W;
  localparam int unsigned NBW = mta_pkg::COUNT_BITS;

  function automatic logic [QW-1:0] sat_q(input logic neg, input logic ovf,
                                          input logic [UW-1:0] mag);
    logic [QW-1:0] r;
    if (ovf) begin
      r = neg ? mta_pkg::Q_MIN : mta_pkg::Q_MAX;
    end else if (!neg) begin
      r = (mag > {1'b0, mta_pkg::Q_MAX}) ? mta_pkg::Q_MAX : mag[QW-1:0];
    end else begin
      r = (mag > {1'b0, mta_pkg::Q_MIN}) ? mta_pkg::Q_MIN : (~mag[QW-1:0] + 1'b1);
    end
    return r;
  endfunction

  mta_pkg::op_e op;
  assign op = cmd_i.op;

  // Configuration.
  logic bt_en_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bt_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      bt_en_q <= cfg_wdata_i;
    end
  end

  // Item capture: indices and edge deltas.
  logic [mta_pkg::IDX_W-1:0] idx_q [3];
  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DW-1:0] da_q [3];
  logic signed [DW-1:0] db_q [3];

  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_CAPTURE) begin
      idx_q[0] <= first_index_i;
      idx_q[1] <= second_index_i;
      idx_q[2] <= third_index_i;
      du1_q <= {second_texcoord_i[15], second_texcoord_i[15:0]}
             - {first_texcoord_i[15], first_texcoord_i[15:0]};
      dv1_q <= {second_texcoord_i[31], second_texcoord_i[31:16]}
             - {first_texcoord_i[31], first_texcoord_i[31:16]};
      du2_q <= {third_texcoord_i[15], third_texcoord_i[15:0]}
             - {first_texcoord_i[15], first_texcoord_i[15:0]};
      dv2_q <= {third_texcoord_i[31], third_texcoord_i[31:16]}
             - {first_texcoord_i[31], first_texcoord_i[31:16]};
      for (int c = 0; c < 3; c++) begin
        da_q[c] <= {second_position_i[16*c+15], second_position_i[16*c +: 16]}
                 - {first_position_i[16*c+15], first_position_i[16*c +: 16]};
        db_q[c] <= {third_position_i[16*c+15], third_position_i[16*c +: 16]}
                 - {first_position_i[16*c+15], first_position_i[16*c +: 16]};
      end
    end
  end

  // Products: an even step loads the first product, the odd step subtracts
  // the second and stores the difference (determinant, then nT, then nB).
  logic [2:0]           pair;
  logic                 odd;
  logic signed [DW-1:0] ma, mb;
  logic signed [2*DW-1:0] mprod;
  logic signed [PW-1:0] pacc_q, pdiff;
  logic signed [PW-1:0] num_q [7];
  logic                 deg_q;

  assign pair = cmd_i.step[3:1];
  assign odd  = cmd_i.step[0];

  always_comb begin
    ma = du1_q;
    mb = dv2_q;
    case (pair)
      3'd0: begin ma = odd ? dv1_q : du1_q; mb = odd ? du2_q    : dv2_q;    end
      3'd1: begin ma = odd ? dv1_q : dv2_q; mb = odd ? db_q[0]  : da_q[0];  end
      3'd2: begin ma = odd ? dv1_q : dv2_q; mb = odd ? db_q[1]  : da_q[1];  end
      3'd3: begin ma = odd ? dv1_q : dv2_q; mb = odd ? db_q[2]  : da_q[2];  end
      3'd4: begin ma = odd ? du2_q : du1_q; mb = odd ? da_q[0]  : db_q[0];  end
      3'd5: begin ma = odd ? du2_q : du1_q; mb = odd ? da_q[1]  : db_q[1];  end
      3'd6: begin ma = odd ? du2_q : du1_q; mb = odd ? da_q[2]  : db_q[2];  end
      default: begin ma = du1_q; mb = dv2_q; end
    endcase
  end

  assign mprod = ma * mb;
  assign pdiff = pacc_q - {mprod[2*DW-1], mprod};

  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_MUL) begin
      if (!odd) begin
        pacc_q <= {mprod[2*DW-1], mprod};
      end else begin
        num_q[pair] <= pdiff;
        if (pair == 3'd0) begin
          deg_q <= (pdiff == '0);
        end
      end
    end
  end

  // Stores and the read registers of the current corner.
  logic [mta_pkg::VEC_W-1:0]  tmem [mta_pkg::VERTEX_COUNT];
  logic [mta_pkg::VEC_W-1:0]  bmem [mta_pkg::VERTEX_COUNT];
  logic [NBW-1:0]             cmem [mta_pkg::VERTEX_COUNT];
  logic [mta_pkg::VEC_W-1:0]  t_rd_q, b_rd_q, t_new, b_new;
  logic [NBW-1:0]             n_rd_q;
  logic [mta_pkg::ADDR_W-1:0] addr;
  logic signed [QW-1:0]       res_q [4][3];

  assign addr  = idx_q[cmd_i.corner][mta_pkg::ADDR_W-1:0];
  assign t_new = {res_q[2][2], res_q[2][1], res_q[2][0]};
  assign b_new = {res_q[3][2], res_q[3][1], res_q[3][0]};

  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_READ) begin
      t_rd_q <= tmem[addr];
    end
    if (op == mta_pkg::OP_WRITE) begin
      tmem[addr] <= t_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_READ) begin
      b_rd_q <= bmem[addr];
    end
    if (op == mta_pkg::OP_WRITE && bt_en_q) begin
      bmem[addr] <= b_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_READ) begin
      n_rd_q <= cmem[addr];
    end
    if (op == mta_pkg::OP_CLEAR) begin
      cmem[cmd_i.clr_addr] <= '0;
    end else if (op == mta_pkg::OP_WRITE) begin
      cmem[addr] <= (n_rd_q == mta_pkg::COUNT_MAX) ? n_rd_q : n_rd_q + 1'b1;
    end
  end

  // Running mean numerator: old * n + fresh. With n zero the old entry has
  // never been written, so it is ignored and the division by one passes the
  // fresh value through unchanged.
  logic signed [QW-1:0] old_c, fresh_c;
  logic signed [MW-1:0] macc_q, msum;

  assign old_c   = (n_rd_q == '0) ? '0
                 : (cmd_i.vec ? b_rd_q[cmd_i.comp*QW +: QW] : t_rd_q[cmd_i.comp*QW +: QW]);
  assign fresh_c = res_q[{1'b0, cmd_i.vec}][cmd_i.comp];
  assign msum    = $signed({{(MW-QW){old_c[QW-1]}}, old_c})
                 * $signed({{(MW-NBW){1'b0}}, n_rd_q})
                 + $signed({{(MW-QW){fresh_c[QW-1]}}, fresh_c});

  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_MMUL) begin
      macc_q <= msum;
    end
  end

  // Divider set-up: sign, magnitudes and the rounding half-divisor.
  logic [2:0]           nsel;
  logic signed [PW-1:0] snum;
  logic signed [NW-1:0] dnum;
  logic signed [PW-1:0] dden;
  logic [NBW:0]         n_plus;
  logic [NW-1:0]        unum;
  logic [PW-1:0]        uden;
  logic [RW-1:0]        nr;
  logic                 dneg, dovf, start_div;
  logic [QW-1:0]        deg_val;

  assign nsel   = 3'd1 + (cmd_i.vec ? 3'd3 : 3'd0) + {1'b0, cmd_i.comp};
  assign snum   = num_q[nsel];
  assign n_plus = {1'b0, n_rd_q} + 1'b1;

  always_comb begin
    if (op == mta_pkg::OP_MDIV) begin
      dnum = {{(NW-MW){macc_q[MW-1]}}, macc_q};
      dden = {{(PW-NBW-1){1'b0}}, n_plus};
    end else begin
      dnum = {snum[PW-1], snum, 16'b0};
      dden = num_q[0];
    end
  end

  assign dneg = dnum[NW-1] ^ dden[PW-1];
  assign unum = dnum[NW-1] ? (~dnum + 1'b1) : dnum;
  assign uden = dden[PW-1] ? (~dden + 1'b1) : dden;
  assign nr   = {1'b0, unum} + RW'(uden >> 1);
  assign dovf = {{(SW-RW){1'b0}}, nr} >= (SW'(uden) << UW);

  assign start_div = (op == mta_pkg::OP_SOLVE && !deg_q) || op == mta_pkg::OP_MDIV;
  assign deg_val   = (snum == '0) ? '0 : (snum[PW-1] ? mta_pkg::Q_MIN : mta_pkg::Q_MAX);

  // One quotient bit a cycle.
  logic [RW-1:0] rem_q;
  logic [SW-1:0] dsh_q;
  logic [UW-1:0] quo_q, quo_nx;
  logic [CW-1:0] cnt_q;
  logic          busy_q, neg_q, ovf_q, ge, div_done;
  logic [1:0]    dst_q, dcomp_q;

  assign ge       = {{(SW-RW){1'b0}}, rem_q} >= dsh_q;
  assign quo_nx   = {quo_q[UW-2:0], ge};
  assign div_done = busy_q && (cnt_q == CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_div) begin
      busy_q <= 1'b1;
    end else if (div_done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_div) begin
      rem_q   <= nr;
      dsh_q   <= SW'(uden) << (UW - 1);
      quo_q   <= '0;
      cnt_q   <= CW'(UW);
      neg_q   <= dneg;
      ovf_q   <= dovf;
      dst_q   <= {op == mta_pkg::OP_MDIV, cmd_i.vec};
      dcomp_q <= cmd_i.comp;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - RW'(dsh_q);
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= quo_nx;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Results: rows 0 and 1 hold the triangle vectors, rows 2 and 3 the means.
  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_SOLVE && deg_q) begin
      res_q[{1'b0, cmd_i.vec}][cmd_i.comp] <= deg_val;
    end else if (div_done) begin
      res_q[dst_q][dcomp_q] <= sat_q(neg_q, ovf_q, quo_nx);
    end
  end

  // Output register.
  logic                      out_valid_q;
  logic [mta_pkg::IDX_W-1:0] vidx_q;
  logic [mta_pkg::VEC_W-1:0] tan_q, bit_q;
  logic                      odeg_q, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == mta_pkg::OP_WRITE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == mta_pkg::OP_WRITE) begin
      vidx_q <= idx_q[cmd_i.corner];
      tan_q  <= t_new;
      bit_q  <= bt_en_q ? b_new : '0;
      odeg_q <= deg_q;
      last_q <= (cmd_i.corner == 2'd2);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_index_o  = vidx_q;
  assign tangent_o       = tan_q;
  assign bitangent_o     = bit_q;
  assign degenerate_o    = odeg_q;
  assign last_o          = last_q;
  assign stat_o.div_busy = busy_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_busy_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != '0))
    else $error("divider busy with an empty bit count");

  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done && !start_div) |=> !busy_q)
    else $error("divider stayed busy after its last bit");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == mta_pkg::OP_WRITE) |=> out_valid_q)
    else $error("written result not presented");
`endif

endmodule

// ===== rtl/core/mesh_tangent_accumulator.sv =====
// Top level of the mesh tangent accumulator: joins the sequencer and the datapath.
// Depends on mta_pkg, mta_ctrl and mta_dp.
//
//   channel  direction  handshake                 carries
//   in       input      in_valid_i / in_ready_o   one triangle: indices, positions, UVs
//   out      output     out_valid_o / out_ready_i one vertex: index, tangent, bitangent
//   cfg      input      cfg_we_i                  bitangent_enable in cfg_wdata_i
//
// A triangle takes 24 divisions (18 with a zero UV determinant), all served by the
// single divider that yields one quotient bit a cycle.
// After reset a clearing pass over all 4096 entries zeroes the share counts; no item is
// taken during it. Each vertex result waits for its output slot to be free, and a
// new triangle is taken while the third result still waits to be collected.
module mesh_tangent_accumulator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mta_pkg::IDX_W-1:0]  first_index_i,
  input  logic [mta_pkg::IDX_W-1:0]  second_index_i,
  input  logic [mta_pkg::IDX_W-1:0]  third_index_i,
  input  logic [mta_pkg::POS_W-1:0]  first_position_i,
  input  logic [mta_pkg::POS_W-1:0]  second_position_i,
  input  logic [mta_pkg::POS_W-1:0]  third_position_i,
  input  logic [mta_pkg::TEX_W-1:0]  first_texcoord_i,
  input  logic [mta_pkg::TEX_W-1:0]  second_texcoord_i,
  input  logic [mta_pkg::TEX_W-1:0]  third_texcoord_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mta_pkg::IDX_W-1:0]  vertex_index_o,
  output logic [mta_pkg::VEC_W-1:0]  tangent_o,
  output logic [mta_pkg::VEC_W-1:0]  bitangent_o,
  output logic                       degenerate_o,
  output logic                       last_o
);

  mta_pkg::cmd_t  cmd;
  mta_pkg::stat_t stat;

  mta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mta_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .first_index_i     (first_index_i),
    .second_index_i    (second_index_i),
    .third_index_i     (third_index_i),
    .first_position_i  (first_position_i),
    .second_position_i (second_position_i),
    .third_position_i  (third_position_i),
    .first_texcoord_i  (first_texcoord_i),
    .second_texcoord_i (second_texcoord_i),
    .third_texcoord_i  (third_texcoord_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .vertex_index_o    (vertex_index_o),
    .tangent_o         (tangent_o),
    .bitangent_o       (bitangent_o),
    .degenerate_o      (degenerate_o),
    .last_o            (last_o)
  );

endmodule

// ===== tb/sv/tb_mesh_tangent_accumulator.sv =====
// Self-checking testbench for mesh_tangent_accumulator: triangles go in, vertex means come out.
// A scoreboard class predicts every vertex result; depends on mta_pkg and the RTL.
module tb_mesh_tangent_accumulator;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 700;

  typedef struct {
    logic [mta_pkg::IDX_W-1:0] idx [3];
    logic [mta_pkg::POS_W-1:0] pos [3];
    logic [mta_pkg::TEX_W-1:0] tex [3];
  } triangle_t;

  typedef struct {
    logic [mta_pkg::IDX_W-1:0] vertex;
    logic [mta_pkg::VEC_W-1:0] tan;
    logic [mta_pkg::VEC_W-1:0] bitan;
    logic                      degen;
    logic                      last;
  } vertex_res_t;

  typedef longint vec3_t [3];

  class tangent_scoreboard;
    logic [mta_pkg::VEC_W-1:0]      tan_mem   [mta_pkg::VERTEX_COUNT];
    logic [mta_pkg::VEC_W-1:0]      bit_mem   [mta_pkg::VERTEX_COUNT];
    logic [mta_pkg::COUNT_BITS-1:0] share_cnt [mta_pkg::VERTEX_COUNT];
    bit                             bit_en;
    vertex_res_t                    expected_q [$];
    int                             errors;

    function new();
      for (int i = 0; i < mta_pkg::VERTEX_COUNT; i++) begin
        share_cnt[i] = '0;
        tan_mem[i]   = '0;
        bit_mem[i]   = '0;
      end
      bit_en = 1'b1;
      errors = 0;
    endfunction

    function longint round_div(longint n, longint d);
      bit     neg;
      longint un, ud, q;
      neg = (n < 0) != (d < 0);
      un  = (n < 0) ? -n : n;
      ud  = (d < 0) ? -d : d;
      q   = (un + ud / 2) / ud;
      return neg ? -q : q;
    endfunction

    function longint clamp20(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
    endfunction

    function logic [mta_pkg::VEC_W-1:0] pack_vec(vec3_t c);
      logic [mta_pkg::Q_W-1:0] x, y, z;
      x = c[0][mta_pkg::Q_W-1:0];
      y = c[1][mta_pkg::Q_W-1:0];
      z = c[2][mta_pkg::Q_W-1:0];
      return {z, y, x};
    endfunction

    function logic [mta_pkg::VEC_W-1:0] fold_mean(logic [mta_pkg::VEC_W-1:0] old,
                                                  vec3_t fresh,
                                                  logic [mta_pkg::COUNT_BITS-1:0] n);
      vec3_t                   r;
      logic [mta_pkg::Q_W-1:0] part;
      longint                  o;
      if (n == 0) return pack_vec(fresh);
      for (int c = 0; c < 3; c++) begin
        part = old[mta_pkg::Q_W*c +: mta_pkg::Q_W];
        o    = $signed(part);
        r[c] = clamp20(round_div(o * longint'(n) + fresh[c], longint'(n) + 1));
      end
      return pack_vec(r);
    endfunction

    function void solve_vec(vec3_t num, longint det, output vec3_t res);
      for (int c = 0; c < 3; c++) begin
        if (det == 0)
          res[c] = (num[c] > 0) ? 524287 : ((num[c] < 0) ? -524288 : 0);
        else
          res[c] = clamp20(round_div(num[c] * 65536, det));
      end
    endfunction

    function void note_triangle(triangle_t t);
      longint         p [3][3];
      longint         u [3], v [3];
      longint         du1, dv1, du2, dv2, det, da, db;
      vec3_t          nt, nb, tv, bv;
      logic [15:0]    h;
      int             slot;
      vertex_res_t    r;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          h = t.pos[k][16*c +: 16];
          p[k][c] = $signed(h);
        end
        h = t.tex[k][15:0];
        u[k] = $signed(h);
        h = t.tex[k][31:16];
        v[k] = $signed(h);
      end
      du1 = u[1] - u[0];
      dv1 = v[1] - v[0];
      du2 = u[2] - u[0];
      dv2 = v[2] - v[0];
      det = du1 * dv2 - dv1 * du2;
      for (int c = 0; c < 3; c++) begin
        da    = p[1][c] - p[0][c];
        db    = p[2][c] - p[0][c];
        nt[c] = dv2 * da - dv1 * db;
        nb[c] = du1 * db - du2 * da;
      end
      solve_vec(nt, det, tv);
      solve_vec(nb, det, bv);
      for (int k = 0; k < 3; k++) begin
        slot = t.idx[k] % mta_pkg::VERTEX_COUNT;
        tan_mem[slot] = fold_mean(tan_mem[slot], tv, share_cnt[slot]);
        if (bit_en) begin
          bit_mem[slot] = fold_mean(bit_mem[slot], bv, share_cnt[slot]);
        end
        if (share_cnt[slot] != mta_pkg::COUNT_MAX) share_cnt[slot]++;
        r.vertex = t.idx[k];
        r.tan    = tan_mem[slot];
        r.bitan  = bit_en ? bit_mem[slot] : '0;
        r.degen  = (det == 0);
        r.last   = (k == 2);
        expected_q.push_back(r);
      end
    endfunction

    function void check_result(vertex_res_t got);
      vertex_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result for vertex %0d", $time, got.vertex);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.vertex !== want.vertex) begin
        $display("%0t: vertex_index expected %h actual %h", $time, want.vertex, got.vertex);
        errors++;
      end
      if (got.tan !== want.tan) begin
        $display("%0t: tangent expected %h actual %h", $time, want.tan, got.tan);
        errors++;
      end
      if (got.bitan !== want.bitan) begin
        $display("%0t: bitangent expected %h actual %h", $time, want.bitan, got.bitan);
        errors++;
      end
      if (got.degen !== want.degen) begin
        $display("%0t: degenerate expected %b actual %b", $time, want.degen, got.degen);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [mta_pkg::IDX_W-1:0] first_index_i = '0, second_index_i = '0, third_index_i = '0;
  logic [mta_pkg::POS_W-1:0] first_position_i = '0, second_position_i = '0;
  logic [mta_pkg::POS_W-1:0] third_position_i = '0;
  logic [mta_pkg::TEX_W-1:0] first_texcoord_i = '0, second_texcoord_i = '0;
  logic [mta_pkg::TEX_W-1:0] third_texcoord_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [mta_pkg::IDX_W-1:0] vertex_index_o;
  logic [mta_pkg::VEC_W-1:0] tangent_o, bitangent_o;
  logic degenerate_o, last_o;

  tangent_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned results_seen = 0;
  bit          quiet = 1'b0;
  bit          held_off = 1'b0;
  int unsigned hold_left = 0;

  mesh_tangent_accumulator u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .first_index_i, .second_index_i, .third_index_i,
    .first_position_i, .second_position_i, .third_position_i,
    .first_texcoord_i, .second_texcoord_i, .third_texcoord_i,
    .out_valid_o, .out_ready_i,
    .vertex_index_o, .tangent_o, .bitangent_o, .degenerate_o, .last_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    vertex_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.vertex = vertex_index_o;
      got.tan    = tangent_o;
      got.bitan  = bitangent_o;
      got.degen  = degenerate_o;
      got.last   = last_o;
      sb.check_result(got);
      results_seen++;
    end
  end

  // Receiver: rare random stalls, and once a long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (!held_off && results_seen >= 90) begin
      held_off  = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 6);
    end
  end

  task automatic write_enable(bit val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    sb.bit_en = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_triangle(triangle_t t);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < 50) @(negedge clk_i);
    end
    first_index_i     <= t.idx[0];
    second_index_i    <= t.idx[1];
    third_index_i     <= t.idx[2];
    first_position_i  <= t.pos[0];
    second_position_i <= t.pos[1];
    third_position_i  <= t.pos[2];
    first_texcoord_i  <= t.tex[0];
    second_texcoord_i <= t.tex[1];
    third_texcoord_i  <= t.tex[2];
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_triangle(t);
    @(negedge clk_i);
  endtask

  function automatic logic [mta_pkg::IDX_W-1:0] pick_index(bit hot_only);
    int unsigned r;
    r = $urandom_range(99);
    if (hot_only) begin
      return (r < 90) ? mta_pkg::IDX_W'($urandom_range(7)) : {mta_pkg::IDX_W{1'b1}};
    end
    if (r < 40) return '0;
    if (r < 70) return mta_pkg::IDX_W'($urandom_range(7, 1));
    if (r < 80) return mta_pkg::IDX_W'($urandom_range(4095, 4088));
    return mta_pkg::IDX_W'($urandom);
  endfunction

  function automatic logic [15:0] pick_half();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    if (r < 5) return 16'($signed($urandom_range(1024)) - 512);
    return 16'($urandom);
  endfunction

  function automatic triangle_t random_triangle(bit hot_only);
    triangle_t t;
    int unsigned shape;
    bit all_zero;
    all_zero = !hot_only && ($urandom_range(99) < 25);
    for (int k = 0; k < 3; k++) begin
      t.idx[k] = all_zero ? '0 : pick_index(hot_only);
      t.pos[k] = {pick_half(), pick_half(), pick_half()};
      t.tex[k] = {pick_half(), pick_half()};
    end
    // A share of triangles gets a zero UV determinant, by equal or collinear UVs.
    shape = $urandom_range(99);
    if (shape < 8) t.tex[2] = t.tex[0];
    else if (shape < 14) t.tex[1] = t.tex[2];
    else if (shape < 18) begin
      t.tex[0] = 32'h0000_0000;
      t.tex[1] = 32'h0100_0100;
      t.tex[2] = 32'h0200_0200;
    end
    return t;
  endfunction

  function automatic triangle_t make_triangle(logic [mta_pkg::IDX_W-1:0] a, b, c,
                                              logic [mta_pkg::POS_W-1:0] pa, pb, pc,
                                              logic [mta_pkg::TEX_W-1:0] ta, tb, tc);
    triangle_t t;
    t.idx = '{a, b, c};
    t.pos = '{pa, pb, pc};
    t.tex = '{ta, tb, tc};
    return t;
  endfunction

  initial begin
    triangle_t dir_q [$];
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_enable(1'b1);

    // Directed: plain, extremes, zero determinant, zero numerator, repeated and top index.
    dir_q.push_back(make_triangle(0, 1, 2, 48'h0, 48'h0000_0000_0100, 48'h0000_0100_0000,
                                  32'h0, 32'h0000_1000, 32'h1000_0000));
    dir_q.push_back(make_triangle(3, 4, 5, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}},
                                  32'h8000_8000, 32'h7fff_8000, 32'h8000_7fff));
    dir_q.push_back(make_triangle(6, 7, 4095, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}},
                                  32'h7fff_7fff, 32'h8000_8000, 32'h7fff_8000));
    dir_q.push_back(make_triangle(0, 3, 6, 48'h0, 48'h0001_0002_0003, 48'hfff0_0010_0000,
                                  32'h1234_1234, 32'h1234_1234, 32'h1234_1234));
    dir_q.push_back(make_triangle(1, 4, 7, 48'h0005_0005_0005, 48'h0005_0005_0005,
                                  48'h0005_0005_0005, 32'h0, 32'h0000_1000, 32'h1000_0000));
    dir_q.push_back(make_triangle(2, 2, 2, 48'h0100_0200_0300, 48'hff00_0000_0100,
                                  48'h0000_fe00_0000, 32'h0, 32'h0001_0000, 32'h0000_0001));
    dir_q.push_back(make_triangle(4095, 4094, 4095, {3{16'h7fff}}, {3{16'h8000}},
                                  48'h0, 32'h0, 32'h0000_0001, 32'h0001_0000));
    dir_q.push_back(make_triangle(5, 0, 5, {3{16'haaaa}}, {3{16'h5555}}, {3{16'hffff}},
                                  32'hffff_0000, 32'h0000_ffff, 32'h5555_aaaa));
    foreach (dir_q[i]) send_triangle(dir_q[i]);
    for (int i = 0; i < 8; i++) send_triangle(random_triangle(1'b0));

    // Bitangents off: only vertices that already hold a bitangent.
    in_valid_i <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    write_enable(1'b0);
    for (int i = 0; i < 30; i++) send_triangle(random_triangle(1'b1));

    in_valid_i <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    write_enable(1'b1);
    for (int i = 0; i < 90; i++) begin
      quiet = (i >= 30 && i < 70);
      send_triangle(random_triangle(1'b0));
    end
    quiet = 1'b0;

    // Bitangents off for good: any index may be used from here on.
    in_valid_i <= 1'b0;
    wait_drained();
    @(negedge clk_i);
    write_enable(1'b0);
    for (int i = 0; i < 40; i++) send_triangle(random_triangle(1'b0));
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
